### rtl/anbs_pkg.sv
// shared types, constants and helpers for the annex b nal splitter
package anbs_pkg;

    // position and length width, fixed by the record format
    localparam int POS_W = 21;

    typedef logic [POS_W-1:0] pos_t;

    // largest byte position of a unit, positions saturate here
    localparam pos_t MAX_UNIT_BYTES = 21'd1048576;

    // access unit delimiter prefix 00 00 00 01 09
    localparam int DELIM_BYTES = 5;
    localparam logic [2:0] DELIM_DONE = 3'd5;

    // start code bytes
    localparam logic [7:0] SC_ZERO = 8'h00;
    localparam logic [7:0] SC_ONE  = 8'h01;

    // zero run saturates at three
    localparam logic [1:0] ZERO_RUN_MAX = 2'd3;
    localparam logic [1:0] ZERO_RUN_SC  = 2'd2;

    // record queue depth and count width
    localparam int QUEUE_DEPTH = 4;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // one nal record
    typedef struct packed {
        pos_t nal_offset;
        pos_t nal_length;
        logic final_nal;
        logic overflow;
    } nal_rec_t;

    // records produced by one byte, rec0 first
    typedef struct packed {
        logic [1:0] rec_count;
        nal_rec_t   rec0;
        nal_rec_t   rec1;
    } core_out_t;

    // status of the record queue
    typedef struct packed {
        logic [CNT_W-1:0] fill;
        logic             has_room;
    } queue_stat_t;

    // expected delimiter byte at a given match position
    function automatic logic [7:0] delim_byte(input logic [2:0] idx);
        logic [7:0] val;
        unique case (idx)
            3'd0:    val = 8'h00;
            3'd1:    val = 8'h00;
            3'd2:    val = 8'h00;
            3'd3:    val = 8'h01;
            3'd4:    val = 8'h09;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

### rtl/anbs_byte_if.sv
// byte channel carrying the access unit stream
interface anbs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/anbs_nal_if.sv
// record channel carrying nal offset and length words
interface anbs_nal_if;
    logic                valid;
    logic                ready;
    anbs_pkg::pos_t      nal_offset;
    anbs_pkg::pos_t      nal_length;
    logic                final_nal;
    logic                overflow;

    modport source (output valid, output nal_offset, output nal_length,
                    output final_nal, output overflow, input ready);
    modport sink (input valid, input nal_offset, input nal_length,
                  input final_nal, input overflow, output ready);
endinterface

### rtl/annexb_nal_unit_splitter_top.sv
// top level of the annex b nal unit splitter
//
// byte_ch takes one access unit byte per word, last_byte set on its final
// byte. nal_ch gives one word per nal unit: payload offset after the start
// code, length, a final flag on the last record of the unit and an
// overflow flag once positions saturate at 1048576.
// a leading 00 00 00 01 09 delimiter and the byte after it are stripped.
// records of a unit appear only after a later start code or the last byte.
// the records a byte closes are written into the record queue when it is taken.
// throughput: one byte per cycle while the queue has room; a byte can make up
// to two records, and they go through a four-entry record queue.
// byte_ch.ready is high while the queue holds two records or fewer, so a
// stalled nal_ch stops intake once the queue fills; nothing is dropped.
// reset clears the scanner state and empties the queue; no unit is open
// after reset, and each last byte returns the scanner to that state.
module annexb_nal_unit_splitter_top (
    input  logic         clk,
    input  logic         rst_n,
    anbs_byte_if.sink    byte_ch,
    anbs_nal_if.source   nal_ch
);

    anbs_pkg::core_out_t   res;
    anbs_pkg::nal_rec_t    head;
    anbs_pkg::queue_stat_t qstat;
    logic                  head_valid;
    logic                  accept;
    logic                  pop;
    logic                  unit_clear;

    // handshakes
    assign byte_ch.ready = qstat.has_room;
    assign accept        = byte_ch.valid && byte_ch.ready;
    assign pop           = nal_ch.valid && nal_ch.ready;

    // scanner
    anbs_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (byte_ch.data_byte),
        .last_byte  (byte_ch.last_byte),
        .res        (res),
        .unit_clear (unit_clear)
    );

    // record queue
    anbs_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .stat       (qstat)
    );

    // output word
    assign nal_ch.valid      = head_valid;
    assign nal_ch.nal_offset = head.nal_offset;
    assign nal_ch.nal_length = head.nal_length;
    assign nal_ch.final_nal  = head.final_nal;
    assign nal_ch.overflow   = head.overflow;

    // queue never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        qstat.fill <= anbs_pkg::CNT_W'(anbs_pkg::QUEUE_DEPTH))
        else $error("record queue over depth");

    // a last byte always leaves a record ready next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && byte_ch.last_byte |=> nal_ch.valid)
        else $error("no record after last byte");

    // a last byte returns the scanner to its empty state
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && byte_ch.last_byte |=> unit_clear)
        else $error("unit state not cleared at end of unit");

    // the queue only grows when a byte is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> qstat.fill <= $past(qstat.fill))
        else $error("records appeared without an input byte");

endmodule

### rtl/anbs_core.sv
// start code scanner: unit state and per-byte record generation
module anbs_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    output anbs_pkg::core_out_t res,
    output logic                unit_clear
);

    anbs_pkg::pos_t pos_reg, pos_next;
    logic [1:0]     zh_reg, zh_next;
    anbs_pkg::pos_t cns_reg, cns_next;
    logic           seen_reg, seen_next;
    logic [2:0]     dcnt_reg, dcnt_next;
    logic           skip_reg, skip_next;
    logic           sat_reg, sat_next;

    anbs_pkg::pos_t      p;
    anbs_pkg::pos_t      p_inc;
    anbs_pkg::pos_t      back;
    anbs_pkg::pos_t      sc;
    anbs_pkg::pos_t      off;
    logic                sat_w;
    logic                go;
    logic                unit_end;
    logic [1:0]          n;
    anbs_pkg::nal_rec_t  rec_mid;
    anbs_pkg::nal_rec_t  rec_end;
    anbs_pkg::nal_rec_t  rec_empty;

    // per-byte next state and records
    always_comb
    begin
        pos_next  = pos_reg;
        zh_next   = zh_reg;
        cns_next  = cns_reg;
        seen_next = seen_reg;
        dcnt_next = dcnt_reg;
        skip_next = skip_reg;
        sat_next  = sat_reg;
        p         = '0;
        p_inc     = '0;
        back      = '0;
        sc        = '0;
        off       = '0;
        sat_w     = 1'b0;
        go        = 1'b0;
        unit_end  = 1'b0;
        n         = 2'd0;
        rec_mid   = '0;
        rec_end   = '0;
        rec_empty = '0;
        rec_empty.final_nal = 1'b1;

        if (skip_reg)
        begin
            // byte after the delimiter prefix is dropped
            skip_next = 1'b0;
            if (last_byte)
            begin
                rec_end  = rec_empty;
                n        = 2'd1;
                unit_end = 1'b1;
            end
        end
        else
        begin
            go = 1'b1;
            // delimiter prefix match
            if (dcnt_reg < anbs_pkg::DELIM_DONE)
            begin
                if (data_byte == anbs_pkg::delim_byte(dcnt_reg))
                begin
                    dcnt_next = dcnt_reg + 3'd1;
                    if (dcnt_reg == anbs_pkg::DELIM_DONE - 3'd1)
                    begin
                        go        = 1'b0;
                        pos_next  = '0;
                        zh_next   = '0;
                        cns_next  = '0;
                        seen_next = 1'b0;
                        sat_next  = 1'b0;
                        if (last_byte)
                        begin
                            rec_end  = rec_empty;
                            n        = 2'd1;
                            unit_end = 1'b1;
                        end
                        else
                        begin
                            skip_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    dcnt_next = anbs_pkg::DELIM_DONE;
                end
            end

            if (go)
            begin
                // saturating position
                sat_w    = sat_reg | (pos_reg >= anbs_pkg::MAX_UNIT_BYTES);
                p        = (pos_reg >= anbs_pkg::MAX_UNIT_BYTES) ?
                           anbs_pkg::MAX_UNIT_BYTES : pos_reg;
                p_inc    = (p >= anbs_pkg::MAX_UNIT_BYTES) ?
                           anbs_pkg::MAX_UNIT_BYTES : p + 1'b1;
                sat_next = sat_w;

                // start code closes on a one after two or more zeros
                if (data_byte == anbs_pkg::SC_ONE && zh_reg >= anbs_pkg::ZERO_RUN_SC)
                begin
                    back = (zh_reg == anbs_pkg::ZERO_RUN_MAX) ? 21'd3 : 21'd2;
                    sc   = (p >= back) ? p - back : '0;
                    if (seen_reg)
                    begin
                        rec_mid.nal_offset = cns_reg;
                        rec_mid.nal_length = (sc > cns_reg) ? sc - cns_reg : '0;
                        rec_mid.final_nal  = 1'b0;
                        rec_mid.overflow   = sat_w;
                        n = 2'd1;
                    end
                    cns_next  = p_inc;
                    seen_next = 1'b1;
                end

                // zero run tracking
                if (data_byte == anbs_pkg::SC_ZERO)
                begin
                    zh_next = (zh_reg == anbs_pkg::ZERO_RUN_MAX) ?
                              anbs_pkg::ZERO_RUN_MAX : zh_reg + 2'd1;
                end
                else
                begin
                    zh_next = '0;
                end

                pos_next = p_inc;

                // final record at end of unit
                if (last_byte)
                begin
                    off = seen_next ? cns_next : '0;
                    rec_end.nal_offset = off;
                    rec_end.nal_length = (p_inc > off) ? p_inc - off : '0;
                    rec_end.final_nal  = 1'b1;
                    rec_end.overflow   = sat_w;
                    n        = n + 2'd1;
                    unit_end = 1'b1;
                end
            end
        end

        // end of unit clears everything
        if (unit_end)
        begin
            pos_next  = '0;
            zh_next   = '0;
            cns_next  = '0;
            seen_next = 1'b0;
            dcnt_next = '0;
            skip_next = 1'b0;
            sat_next  = 1'b0;
        end
    end

    // pack records, mid-unit record goes first
    always_comb
    begin
        res.rec_count = accept ? n : 2'd0;
        if (n == 2'd2)
        begin
            res.rec0 = rec_mid;
            res.rec1 = rec_end;
        end
        else if (rec_end.final_nal)
        begin
            res.rec0 = rec_end;
            res.rec1 = '0;
        end
        else
        begin
            res.rec0 = rec_mid;
            res.rec1 = '0;
        end
    end

    assign unit_clear = (pos_reg == '0) && !seen_reg && (dcnt_reg == '0) && !skip_reg;

    // unit state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            zh_reg   <= '0;
            cns_reg  <= '0;
            seen_reg <= 1'b0;
            dcnt_reg <= '0;
            skip_reg <= 1'b0;
            sat_reg  <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg  <= pos_next;
            zh_reg   <= zh_next;
            cns_reg  <= cns_next;
            seen_reg <= seen_next;
            dcnt_reg <= dcnt_next;
            skip_reg <= skip_next;
            sat_reg  <= sat_next;
        end
    end

endmodule

### rtl/anbs_out_queue.sv
// small shift queue of nal records, up to two pushes and one pop per cycle
module anbs_out_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  anbs_pkg::core_out_t   push,
    input  logic                  pop,
    output anbs_pkg::nal_rec_t    head,
    output logic                  head_valid,
    output anbs_pkg::queue_stat_t stat
);

    anbs_pkg::nal_rec_t           q_reg [anbs_pkg::QUEUE_DEPTH];
    anbs_pkg::nal_rec_t           q_next [anbs_pkg::QUEUE_DEPTH];
    logic [anbs_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [anbs_pkg::CNT_W-1:0]   base;
    logic                         do_pop;

    assign do_pop = pop && (cnt_reg != '0);
    assign base   = cnt_reg - {{(anbs_pkg::CNT_W-1){1'b0}}, do_pop};

    // shift on pop, then append new records
    always_comb
    begin
        for (int i = 0; i < anbs_pkg::QUEUE_DEPTH; i++)
        begin
            if (do_pop && i < anbs_pkg::QUEUE_DEPTH - 1)
            begin
                q_next[i] = q_reg[i+1];
            end
            else
            begin
                q_next[i] = q_reg[i];
            end
            if (push.rec_count != 2'd0 && base == anbs_pkg::CNT_W'(i))
            begin
                q_next[i] = push.rec0;
            end
            if (push.rec_count == 2'd2 && base + 1'b1 == anbs_pkg::CNT_W'(i))
            begin
                q_next[i] = push.rec1;
            end
        end
        cnt_next = base + anbs_pkg::CNT_W'(push.rec_count);
    end

    // record storage
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < anbs_pkg::QUEUE_DEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    // fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign head          = q_reg[0];
    assign head_valid    = (cnt_reg != '0);
    assign stat.fill     = cnt_reg;
    assign stat.has_room = (cnt_reg <= anbs_pkg::CNT_W'(anbs_pkg::QUEUE_DEPTH - 2));

endmodule

### dv/tb_annexb_nal_unit_splitter_top.sv
// testbench for the annex b nal unit splitter: directed and random access units checked against a scan predictor
module tb_annexb_nal_unit_splitter_top;

    timeunit 1ns;
    timeprecision 1ps;

    // access unit delimiter prefix that is stripped at the head of a unit
    localparam logic [7:0] AUD_PREFIX [anbs_pkg::DELIM_BYTES] =
        '{8'h00, 8'h00, 8'h00, 8'h01, 8'h09};
    localparam int unsigned UNIT_LIMIT = anbs_pkg::MAX_UNIT_BYTES;
    localparam int SETTLE_CYCLES = 20;
    localparam int REPORT_MAX = 10;
    localparam int PHASE_BYTES = 100;

    // one byte word waiting to go out, with the idling of its phase
    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         drain_first;
        int unsigned send_gap_pct;
        int unsigned recv_stall_pct;
    } au_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    anbs_byte_if byte_bus ();
    anbs_nal_if  nal_bus ();

    annexb_nal_unit_splitter_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_bus),
        .nal_ch  (nal_bus)
    );

    always #1 clk = ~clk;

    au_word_t              byte_queue[$];
    anbs_pkg::nal_rec_t    nal_expect[$];
    int unsigned error_count = 0;
    int unsigned stall_pct = 0;

    // stimulus build state
    int unsigned cur_send_pct = 0;
    int unsigned cur_recv_pct = 0;
    bit          drain_pending = 0;
    int unsigned bytes_built = 0;
    logic [7:0]  unit_bytes[$];

    // scanner state of the predictor
    int unsigned au_pos;
    int unsigned zero_run;
    int unsigned open_nal_start;
    bit          start_found;
    int unsigned aud_match;
    bit          drop_next;
    bit          pos_saturated;

    function automatic void clear_unit();
        au_pos = 0;
        zero_run = 0;
        open_nal_start = 0;
        start_found = 0;
        aud_match = 0;
        drop_next = 0;
        pos_saturated = 0;
    endfunction

    function automatic void push_record(input int unsigned off, input int unsigned len,
                                        input bit fin, input bit ovf);
        anbs_pkg::nal_rec_t rec;
        rec.nal_offset = off[anbs_pkg::POS_W-1:0];
        rec.nal_length = len[anbs_pkg::POS_W-1:0];
        rec.final_nal  = fin;
        rec.overflow   = ovf;
        nal_expect = {nal_expect, rec};
    endfunction

    // advance the scanner by one byte and queue the records it closes
    function automatic void scan_byte(input logic [7:0] b, input logic last);
        int unsigned p;
        int unsigned back;
        int unsigned sc;
        int unsigned off;
        // byte right after a stripped delimiter is dropped
        if (drop_next)
        begin
            drop_next = 0;
            if (last)
            begin
                push_record(0, 0, 1'b1, 1'b0);
                clear_unit();
            end
            return;
        end
        // delimiter prefix match at the head of the unit
        if (aud_match < anbs_pkg::DELIM_DONE)
        begin
            if (b == AUD_PREFIX[aud_match])
            begin
                aud_match++;
                if (aud_match == anbs_pkg::DELIM_DONE)
                begin
                    au_pos = 0;
                    zero_run = 0;
                    open_nal_start = 0;
                    start_found = 0;
                    pos_saturated = 0;
                    if (last)
                    begin
                        push_record(0, 0, 1'b1, 1'b0);
                        clear_unit();
                    end
                    else
                    begin
                        drop_next = 1;
                    end
                    return;
                end
            end
            else
            begin
                aud_match = anbs_pkg::DELIM_DONE;
            end
        end
        p = au_pos;
        if (p >= UNIT_LIMIT)
        begin
            p = UNIT_LIMIT;
            pos_saturated = 1;
        end
        // start code closes on a 01 after two or more zeros
        if (b == anbs_pkg::SC_ONE && zero_run >= 2)
        begin
            back = (zero_run >= 3) ? 3 : 2;
            sc = (p >= back) ? p - back : 0;
            if (start_found)
                push_record(open_nal_start, (sc > open_nal_start) ? sc - open_nal_start : 0,
                            1'b0, pos_saturated);
            open_nal_start = (p >= UNIT_LIMIT) ? UNIT_LIMIT : p + 1;
            start_found = 1;
        end
        if (b == anbs_pkg::SC_ZERO)
        begin
            if (zero_run < 3)
                zero_run++;
        end
        else
        begin
            zero_run = 0;
        end
        au_pos = (p >= UNIT_LIMIT) ? UNIT_LIMIT : p + 1;
        // last byte flushes the open nal
        if (last)
        begin
            off = start_found ? open_nal_start : 0;
            push_record(off, (au_pos > off) ? au_pos - off : 0, 1'b1, pos_saturated);
            clear_unit();
        end
    endfunction

    // byte driver fed from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_bus.valid <= 1'b0;
            byte_bus.data_byte <= 8'h00;
            byte_bus.last_byte <= 1'b0;
        end
        else
        begin
            if (byte_bus.valid && byte_bus.ready)
                scan_byte(byte_bus.data_byte, byte_bus.last_byte);
            if (!byte_bus.valid || byte_bus.ready)
            begin
                if (byte_queue.size() > 0
                    && (!byte_queue[0].drain_first || nal_expect.size() == 0)
                    && $urandom_range(99) >= byte_queue[0].send_gap_pct)
                begin
                    byte_bus.valid <= 1'b1;
                    byte_bus.data_byte <= byte_queue[0].data;
                    byte_bus.last_byte <= byte_queue[0].last;
                    stall_pct <= byte_queue[0].recv_stall_pct;
                    void'(byte_queue.pop_front());
                end
                else
                begin
                    byte_bus.valid <= 1'b0;
                end
            end
        end
    end

    // record monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        anbs_pkg::nal_rec_t want;
        if (!rst_n)
        begin
            nal_bus.ready <= 1'b0;
        end
        else
        begin
            if (nal_bus.valid && nal_bus.ready)
            begin
                if (nal_expect.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display("unexpected record: off=%0d len=%0d fin=%0b ovf=%0b",
                                 nal_bus.nal_offset, nal_bus.nal_length,
                                 nal_bus.final_nal, nal_bus.overflow);
                end
                else
                begin
                    want = nal_expect.pop_front();
                    if (nal_bus.nal_offset !== want.nal_offset
                        || nal_bus.nal_length !== want.nal_length
                        || nal_bus.final_nal !== want.final_nal
                        || nal_bus.overflow !== want.overflow)
                    begin
                        error_count++;
                        if (error_count <= REPORT_MAX)
                            $display("record mismatch: exp off=%0d len=%0d fin=%0b ovf=%0b, %s",
                                     want.nal_offset, want.nal_length, want.final_nal,
                                     want.overflow,
                                     $sformatf("got off=%0d len=%0d fin=%0b ovf=%0b",
                                               nal_bus.nal_offset, nal_bus.nal_length,
                                               nal_bus.final_nal, nal_bus.overflow));
                    end
                end
            end
            nal_bus.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic set_phase(input int unsigned send_pct, input int unsigned recv_pct);
        cur_send_pct = send_pct;
        cur_recv_pct = recv_pct;
        drain_pending = 1;
    endtask

    task automatic add_byte(input logic [7:0] b, input logic last);
        au_word_t w;
        w.data = b;
        w.last = last;
        w.drain_first = drain_pending;
        w.send_gap_pct = cur_send_pct;
        w.recv_stall_pct = cur_recv_pct;
        byte_queue = {byte_queue, w};
        drain_pending = 0;
        bytes_built++;
    endtask

    // send the collected unit bytes, last flag on the final one
    task automatic flush_unit();
        foreach (unit_bytes[i])
            add_byte(unit_bytes[i], i == unit_bytes.size() - 1);
        unit_bytes.delete();
    endtask

    // byte biased toward start code material
    function automatic logic [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(9);
        if (r < 3)
            return anbs_pkg::SC_ZERO;
        else if (r == 3)
            return anbs_pkg::SC_ONE;
        return 8'($urandom_range(255));
    endfunction

    task automatic add_start_code();
        if ($urandom_range(1))
            unit_bytes = {unit_bytes, anbs_pkg::SC_ZERO};
        unit_bytes = {unit_bytes, anbs_pkg::SC_ZERO};
        unit_bytes = {unit_bytes, anbs_pkg::SC_ZERO};
        unit_bytes = {unit_bytes, anbs_pkg::SC_ONE};
    endtask

    task automatic add_random_unit();
        int unsigned kind;
        int unsigned n;
        kind = $urandom_range(99);
        if (kind < 10)
        begin
            // noise unit
            n = $urandom_range(1, 12);
            repeat (n) unit_bytes = {unit_bytes, pick_byte()};
        end
        else if (kind < 18)
        begin
            // delimiter cut short, complete, or ending on the dropped byte
            n = $urandom_range(1, anbs_pkg::DELIM_BYTES + 1);
            for (int i = 0; i < n; i++)
                unit_bytes = {unit_bytes, (i < anbs_pkg::DELIM_BYTES) ?
                              AUD_PREFIX[i] : 8'($urandom_range(255))};
        end
        else
        begin
            // well-formed unit with random content
            if ($urandom_range(1))
            begin
                foreach (AUD_PREFIX[i])
                    unit_bytes = {unit_bytes, AUD_PREFIX[i]};
                unit_bytes = {unit_bytes, 8'($urandom_range(255))};
            end
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 2))
                    unit_bytes = {unit_bytes, 8'($urandom_range(2, 255))};
            repeat ($urandom_range(1, 4))
            begin
                add_start_code();
                repeat ($urandom_range(0, 6)) unit_bytes = {unit_bytes, pick_byte()};
            end
        end
        flush_unit();
    endtask

    task automatic add_phase(input int unsigned send_pct, input int unsigned recv_pct);
        int unsigned target;
        set_phase(send_pct, recv_pct);
        target = bytes_built + PHASE_BYTES;
        while (bytes_built < target)
            add_random_unit();
    endtask

    // stimulus, reset and end of run
    initial
    begin
        clear_unit();

        // directed units, no idling
        set_phase(0, 0);
        // one byte, no start code
        unit_bytes = {8'hFF};
        flush_unit();
        // unit ends on the fifth delimiter byte
        unit_bytes = {8'h00, 8'h00, 8'h00, 8'h01, 8'h09};
        flush_unit();
        // unit ends on the dropped byte
        unit_bytes = {8'h00, 8'h00, 8'h00, 8'h01, 8'h09, 8'h7E};
        flush_unit();
        // a leading byte, 3-byte and 4-byte codes, start code at the very end
        unit_bytes = {8'h80, 8'h00, 8'h00, 8'h01, 8'h55, 8'h00, 8'h00, 8'h00, 8'h01};
        flush_unit();
        // unit ends inside the delimiter
        unit_bytes = {8'h00, 8'h00, 8'h00};
        flush_unit();

        // random units in each idling mix, draining the block first
        add_phase(0, 0);
        add_phase(61, 0);
        add_phase(0, 61);
        add_phase(11, 11);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_queue.size() != 0 || byte_bus.valid || nal_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0 && nal_expect.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

### annexb_nal_unit_splitter_top.f
rtl/anbs_pkg.sv
rtl/anbs_byte_if.sv
rtl/anbs_nal_if.sv
rtl/anbs_core.sv
rtl/anbs_out_queue.sv
rtl/annexb_nal_unit_splitter_top.sv
dv/tb_annexb_nal_unit_splitter_top.sv
